[hdl/pdc_pkg.sv]
// Shared constants, types and CRC step for the packet deframer.
package pdc_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int BYTE_W = 8;
   localparam int LEN_W = 7;
   localparam int IDX_W = 6;
   localparam int PAYLOAD_DEPTH = 64;
   localparam int CRC_W = 16;

   localparam logic [BYTE_W-1:0] SOP_BYTE = 8'hA1;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   // Packet handed from the parser to the emitter
   typedef struct packed {
      logic              start;
      logic [BYTE_W-1:0] ptype;
      logic [LEN_W-1:0]  plen;
   } job_type;

   // Payload store write port
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

   // One byte of the reflected CCITT CRC (poly 0x8408)
   function automatic logic [CRC_W-1:0] crc_feed(input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0] crc);
      logic [7:0] x;
      x = b ^ crc[7:0];
      x = x ^ {x[3:0], 4'b0000};
      return {x, crc[15:8]} ^ {12'b0, x[7:4]} ^ {5'b0, x, 3'b000};
   endfunction

endpackage

[hdl/pdc_if.sv]
// Request and response channel interfaces of the packet deframer.
interface pdc_req_if;
   logic                       valid;
   logic                       ready;
   logic [pdc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pdc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pdc_pkg::BYTE_W-1:0] pkt_type;
   logic [pdc_pkg::LEN_W-1:0]  pkt_length;
   logic [pdc_pkg::IDX_W-1:0]  byte_index;
   logic [pdc_pkg::BYTE_W-1:0] data_byte;
   logic                       has_data;
   logic                       last;

   modport source (output valid, output pkt_type, output pkt_length, output byte_index,
                   output data_byte, output has_data, output last, input ready);
   modport sink (input valid, input pkt_type, input pkt_length, input byte_index,
                 input data_byte, input has_data, input last, output ready);
endinterface

[hdl/pdc_ram.sv]
// Generic simple dual-port RAM with registered read.
module pdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/pdc_parser.sv]
// Header parser, CRC check and payload write for the packet deframer.
module pdc_parser (
   input  logic                 clock,
   input  logic                 reset,
   pdc_req_if.sink              req_ch,
   input  logic                 emit_busy,
   output pdc_pkg::job_type     job,
   output pdc_pkg::mem_wr_type  wr
);
   import pdc_pkg::*;

   localparam logic [2:0] ST_HUNT    = 3'd0;
   localparam logic [2:0] ST_SOP     = 3'd1;
   localparam logic [2:0] ST_TYPE    = 3'd2;
   localparam logic [2:0] ST_LEN     = 3'd3;
   localparam logic [2:0] ST_CRCLO   = 3'd4;
   localparam logic [2:0] ST_PAYLOAD = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CRC_W-1:0]  rcrc_ff, rcrc_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic [CRC_W-1:0]  crc_fed;
   logic [LEN_W-1:0]  cnt_plus;
   logic              done;
   logic              match;

   assign req_ch.ready = !emit_busy;
   assign accept = req_ch.valid && req_ch.ready;
   assign b = req_ch.rx_byte;
   assign crc_fed = crc_feed(b, crc_ff);
   assign cnt_plus = cnt_ff + LEN_W'(1);

   always_comb begin
      state_in = state_ff;
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      type_in = type_ff;
      len_in = len_ff;
      rcrc_in = rcrc_ff;
      done = 1'b0;
      match = 1'b0;
      wr.en = 1'b0;
      wr.addr = cnt_ff[IDX_W-1:0];
      wr.data = b;
      if (accept) begin
         case (state_ff)
            ST_SOP: begin
               type_in = b;
               crc_in = crc_fed;
               state_in = ST_TYPE;
            end
            ST_TYPE: begin
               len_in = b[LEN_W-1:0];
               crc_in = crc_fed;
               state_in = (b > BYTE_W'(MAX_PAYLOAD)) ? ST_HUNT : ST_LEN;
            end
            ST_LEN: begin
               rcrc_in = {8'h00, b};
               state_in = ST_CRCLO;
            end
            ST_CRCLO: begin
               rcrc_in = {b, rcrc_ff[7:0]};
               if (len_ff != '0) begin
                  state_in = ST_PAYLOAD;
               end else begin
                  done = 1'b1;
                  match = (crc_ff == {b, rcrc_ff[7:0]});
               end
            end
            ST_PAYLOAD: begin
               wr.en = 1'b1;
               cnt_in = cnt_plus;
               crc_in = crc_fed;
               if (cnt_plus >= len_ff) begin
                  done = 1'b1;
                  match = (crc_fed == rcrc_ff);
               end
            end
            default: begin
               // hunt; unused codes land here too
               if (b == SOP_BYTE) begin
                  crc_in = CRC_INIT;
                  cnt_in = '0;
                  state_in = ST_SOP;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         endcase
      end
      if (done) begin
         state_in = ST_HUNT;
         cnt_in = '0;
      end
   end

   assign job.start = done && match;
   assign job.ptype = type_ff;
   assign job.plen = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         crc_ff <= CRC_INIT;
         cnt_ff <= '0;
         type_ff <= '0;
         len_ff <= '0;
         rcrc_ff <= '0;
      end else begin
         state_ff <= state_in;
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
         type_ff <= type_in;
         len_ff <= len_in;
         rcrc_ff <= rcrc_in;
      end
   end
endmodule

[hdl/pdc_emitter.sv]
// Payload readout from the store into the response register.
module pdc_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  pdc_pkg::job_type          job,
   output logic                      busy,
   output logic                      rd_en,
   output logic [pdc_pkg::IDX_W-1:0] rd_addr,
   input  logic [pdc_pkg::BYTE_W-1:0] rd_data,
   pdc_rsp_if.source                 rsp_ch
);
   import pdc_pkg::*;

   logic              act_ff, act_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              pend_empty_ff, pend_empty_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [BYTE_W-1:0] jtype_ff, jtype_in;
   logic [LEN_W-1:0]  jlen_ff, jlen_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_type_ff, out_type_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic              out_has_ff, out_has_in;
   logic              out_last_ff, out_last_in;

   logic load;
   logic issue;
   logic issue_last;

   // Move the read result into the output register when it is free or draining
   assign load = pend_ff && (!out_valid_ff || rsp_ch.ready);
   assign issue = act_ff && (!pend_ff || load);
   assign issue_last = (LEN_W'(idx_ff) + LEN_W'(1)) == jlen_ff;

   assign busy = act_ff || pend_ff;
   assign rd_en = issue;
   assign rd_addr = idx_ff;

   always_comb begin
      act_in = act_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pend_empty_in = pend_empty_ff;
      pend_idx_in = pend_idx_ff;
      jtype_in = jtype_ff;
      jlen_in = jlen_ff;
      out_valid_in = out_valid_ff;
      out_type_in = out_type_ff;
      out_len_in = out_len_ff;
      out_idx_in = out_idx_ff;
      out_data_in = out_data_ff;
      out_has_in = out_has_ff;
      out_last_in = out_last_ff;

      if (load) begin
         out_valid_in = 1'b1;
         out_type_in = jtype_ff;
         out_len_in = jlen_ff;
         out_idx_in = pend_idx_ff;
         out_data_in = pend_empty_ff ? '0 : rd_data;
         out_has_in = !pend_empty_ff;
         out_last_in = pend_empty_ff || ((LEN_W'(pend_idx_ff) + LEN_W'(1)) == jlen_ff);
         pend_in = 1'b0;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      if (issue) begin
         pend_in = 1'b1;
         pend_empty_in = 1'b0;
         pend_idx_in = idx_ff;
         if (issue_last) begin
            act_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      if (job.start) begin
         jtype_in = job.ptype;
         jlen_in = job.plen;
         idx_in = '0;
         if (job.plen == '0) begin
            // empty packet: one result, no store read
            pend_in = 1'b1;
            pend_empty_in = 1'b1;
            pend_idx_in = '0;
         end else begin
            act_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         pend_ff <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pend_empty_ff <= pend_empty_in;
      pend_idx_ff <= pend_idx_in;
      jtype_ff <= jtype_in;
      jlen_ff <= jlen_in;
      out_type_ff <= out_type_in;
      out_len_ff <= out_len_in;
      out_idx_ff <= out_idx_in;
      out_data_ff <= out_data_in;
      out_has_ff <= out_has_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.pkt_type = out_type_ff;
   assign rsp_ch.pkt_length = out_len_ff;
   assign rsp_ch.byte_index = out_idx_ff;
   assign rsp_ch.data_byte = out_data_ff;
   assign rsp_ch.has_data = out_has_ff;
   assign rsp_ch.last = out_last_ff;
endmodule

[hdl/packet_deframer_crc16.sv]
// Packet deframer: start byte, type, length, CRC-16 header, checked payload.
//
// req_ch carries one received byte per request (valid/ready). The parser hunts
// for 0xA1, then takes type, length (0..64) and the CRC low byte first, then
// the payload, which is written into a 64-byte store. While a header or payload
// is parsed, one byte is taken every cycle.
// When the final byte of a packet with a matching CRC arrives, the emitter
// reads the store one entry per cycle while rsp_ch is not stalled and sends
// one response per payload byte on rsp_ch, last set on the final one; an empty
// packet gives one response without data. req_ch.ready is low from the cycle
// after that byte until the last store read has moved into the response
// register, which a stall on rsp_ch delays. The first response passes the
// readout start, the store read and the response register in turn; an empty
// packet skips the readout start. The store port (one write, one read a cycle) sets
// the readout rate.
// A stalled receiver holds the response register and the readout; new bytes
// are taken again once the last read has left for the response register.
// Reset returns the parser to hunting and empties the response register;
// the store is not cleared.
module packet_deframer_crc16 (
   input  logic      clock,
   input  logic      reset,
   pdc_req_if.sink   req_ch,
   pdc_rsp_if.source rsp_ch
);
   import pdc_pkg::*;

   job_type           job;
   mem_wr_type        wr;
   logic              emit_busy;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   pdc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .emit_busy (emit_busy),
      .job       (job),
      .wr        (wr)
   );

   pdc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pdc_emitter u_emitter (
      .clock   (clock),
      .reset   (reset),
      .job     (job),
      .busy    (emit_busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp_ch  (rsp_ch)
   );

`ifndef SYNTHESIS
   // A good packet closes the request side in the next cycle
   a_job_blocks: assert property (@(posedge clock) disable iff (reset)
      job.start |=> !req_ch.ready)
      else $error("request accepted during payload readout");

   // No store write while the emitter reads it out
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !wr.en)
      else $error("payload store written during readout");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.has_data && rsp_ch.last) |->
         ((LEN_W'(rsp_ch.byte_index) + LEN_W'(1)) == rsp_ch.pkt_length))
      else $error("last flag on wrong byte index");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.has_data) |->
         (rsp_ch.last && rsp_ch.pkt_length == '0 && rsp_ch.data_byte == '0))
      else $error("malformed empty packet response");
`endif
endmodule
